// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window maximum unit.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned WindowMaxDef = 64;  // deque depth, cells in the row
  localparam int unsigned DataWidthDef = 16;  // sample width
  localparam int unsigned CfgWidth     = 7;   // window_size register width
  localparam logic [CfgWidth-1:0] WindowSizeReset = CfgWidth'(1);

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic load;   // a sample request is taken this cycle
    logic shift;  // drop the front candidate, row moves one cell forward
    logic clear;  // start of sequence: empty the deque first
  } cell_ctrl_t;

endpackage

// ===== rtl/sliding_window_maximum_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_unit
// Running maximum of the last window_size signed samples.
// ----------------------------------------------------------------------------
// Samples arrive on the s_axis request channel; tuser marks the first sample
// of a sequence (deque and counters are cleared before it is taken), tlast is
// carried through to the result. Once window_size samples of the current
// sequence have arrived, every sample yields one result on m_axis holding the
// window maximum; earlier samples yield none.
// The user writes window_size through cfg_we_i/cfg_wdata_i only while the unit is
// idle; the block does not enforce this. 0 acts as 1 and values above WINDOW_MAX
// act as WINDOW_MAX. A result is valid in the cycle after its sample request is
// taken. Throughput: one sample per cycle when not stalled or purging; every cell
// of the row updates in parallel and only the front cell's age compare sits in
// the ready path. After window_size is reduced, s_axis_tready_o stays low while
// aged-out candidates are popped from the front, one per cycle.
// Reset: clears the deque valid bits, the counters and the result valid;
// window_size returns to 1. No clearing pass is needed.
// Stall: the result is held in the output register; while it waits, no new
// sample request is taken.
// ----------------------------------------------------------------------------
module sliding_window_maximum_unit #(
  parameter int unsigned WINDOW_MAX = swm_pkg::WindowMaxDef,
  parameter int unsigned DATA_WIDTH = swm_pkg::DataWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [swm_pkg::CfgWidth-1:0]         cfg_wdata_i,     // window_size
  // sample stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,  // sample
  input  logic                                 s_axis_tuser_i,  // first_of_sequence
  input  logic                                 s_axis_tlast_i,  // last_of_sequence
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata_o,  // window_max
  output logic                                 m_axis_tlast_o   // last_result
);
  import swm_pkg::*;

  localparam int unsigned TDataWidth = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned WWidth     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PosWidth   = $clog2(2 * WINDOW_MAX);
  localparam int unsigned CmpWidth   = (WWidth > CfgWidth) ? WWidth : CfgWidth;

  // -------------------------------------------------------------------------
  // Configuration register and effective window
  // -------------------------------------------------------------------------
  logic [CfgWidth-1:0] window_size_q;
  logic [CmpWidth-1:0] ws_ext, w_ext;
  logic [WWidth-1:0]   w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WindowSizeReset;
    end else if (cfg_we_i) begin
      window_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    ws_ext = CmpWidth'(window_size_q);
    if (ws_ext == '0) begin
      w_ext = CmpWidth'(1);
    end else if (ws_ext > CmpWidth'(WINDOW_MAX)) begin
      w_ext = CmpWidth'(WINDOW_MAX);
    end else begin
      w_ext = ws_ext;
    end
    w_eff = WWidth'(w_ext);
  end

  // -------------------------------------------------------------------------
  // Cell row: cell 0 is the deque front
  // -------------------------------------------------------------------------
  logic                         chain_valid [WINDOW_MAX:0];
  logic signed [DATA_WIDTH-1:0] chain_value [WINDOW_MAX:0];
  logic [PosWidth-1:0]          chain_pos   [WINDOW_MAX:0];
  logic                         chain_keep  [WINDOW_MAX:0];
  logic signed [DATA_WIDTH-1:0] value_next  [WINDOW_MAX-1:0];

  cell_ctrl_t                   ctrl;
  logic signed [DATA_WIDTH-1:0] sample;
  logic [PosWidth-1:0]          sample_pos_q, pos_cur, pos_next;
  logic [WWidth-1:0]            filled_q, fill_base, fill_next;

  logic [PosWidth:0]            age_diff, age_wrap;
  logic [PosWidth-1:0]          front_age;
  logic                         purge, evict, s_fire, produce;

  logic                         out_valid_q;
  logic signed [DATA_WIDTH-1:0] out_data_q;
  logic                         out_last_q;

  assign chain_valid[WINDOW_MAX] = 1'b0;
  assign chain_value[WINDOW_MAX] = '0;
  assign chain_pos[WINDOW_MAX]   = '0;
  assign chain_keep[0]           = 1'b1;  // front may always take the new sample

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    swm_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .POS_WIDTH  (PosWidth)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .sample_i     (sample),
      .sample_pos_i (pos_cur),
      .nbr_valid_i  (chain_valid[k+1]),
      .nbr_value_i  (chain_value[k+1]),
      .nbr_pos_i    (chain_pos[k+1]),
      .prev_keep_i  (chain_keep[k]),
      .keep_o       (chain_keep[k+1]),
      .valid_o      (chain_valid[k]),
      .value_o      (chain_value[k]),
      .pos_o        (chain_pos[k]),
      .value_next_o (value_next[k])
    );
  end

  // -------------------------------------------------------------------------
  // Front age, relative to the position the next sample will get
  // -------------------------------------------------------------------------
  always_comb begin
    age_diff = {1'b0, sample_pos_q} - {1'b0, chain_pos[0]};
    age_wrap = age_diff + (PosWidth+1)'(2 * WINDOW_MAX);
    front_age = age_diff[PosWidth] ? age_wrap[PosWidth-1:0] : age_diff[PosWidth-1:0];
  end

  // Front older than the window even for the next sample: only after the
  // window shrinks. Trim before taking more samples.
  assign purge = chain_valid[0] && (front_age > PosWidth'(w_eff));
  // Front leaves the window exactly with the next sample.
  assign evict = chain_valid[0] && (front_age >= PosWidth'(w_eff));

  assign s_axis_tready_o = !purge && (!out_valid_q || m_axis_tready_i);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign sample          = s_axis_tdata_i[DATA_WIDTH-1:0];

  always_comb begin
    ctrl.load  = s_fire;
    ctrl.clear = s_fire && s_axis_tuser_i;
    ctrl.shift = s_fire ? (!s_axis_tuser_i && evict) : purge;
  end

  // -------------------------------------------------------------------------
  // Sequence counters
  // -------------------------------------------------------------------------
  always_comb begin
    pos_cur   = s_axis_tuser_i ? '0 : sample_pos_q;
    pos_next  = (pos_cur == PosWidth'(2 * WINDOW_MAX - 1)) ? '0 : pos_cur + 1'b1;
    fill_base = s_axis_tuser_i ? '0 : filled_q;
    fill_next = (fill_base < w_eff) ? fill_base + 1'b1 : fill_base;
    produce   = (fill_next >= w_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_pos_q <= '0;
      filled_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s_fire) begin
        sample_pos_q <= pos_next;
        filled_q     <= fill_next;
      end
      if (s_fire && produce) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload: front of the deque after this sample is appended
  always_ff @(posedge clk_i) begin
    if (s_fire && produce) begin
      out_data_q <= value_next[0];
      out_last_q <= s_axis_tlast_i;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDataWidth'($unsigned(out_data_q));
  assign m_axis_tlast_o  = out_last_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // after a sample, no candidate is older than the window
  a_front_age : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !cfg_we_i) |=> (!chain_valid[0] || front_age <= PosWidth'(w_eff)))
    else $error("deque front outside the window after a sample");

  for (genvar k = 0; k + 1 < WINDOW_MAX; k++) begin : g_chk
    // occupied cells form a prefix of the row
    a_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
      chain_valid[k+1] |-> chain_valid[k])
      else $error("deque has a hole");
    // values never increase from front to back
    a_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (chain_valid[k] && chain_valid[k+1]) |-> (chain_value[k] >= chain_value[k+1]))
      else $error("deque order broken");
  end

endmodule

// ===== rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// One deque slot: holds a candidate value and its arrival position.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int unsigned DATA_WIDTH = swm_pkg::DataWidthDef,
  parameter int unsigned POS_WIDTH  = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swm_pkg::cell_ctrl_t         ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] sample_i,
  input  logic [POS_WIDTH-1:0]        sample_pos_i,
  // neighbor toward the back of the deque
  input  logic                        nbr_valid_i,
  input  logic signed [DATA_WIDTH-1:0] nbr_value_i,
  input  logic [POS_WIDTH-1:0]        nbr_pos_i,
  // neighbor toward the front keeps its candidate (tied high at the front)
  input  logic                        prev_keep_i,
  output logic                        keep_o,
  output logic                        valid_o,
  output logic signed [DATA_WIDTH-1:0] value_o,
  output logic [POS_WIDTH-1:0]        pos_o,
  output logic signed [DATA_WIDTH-1:0] value_next_o
);
  import swm_pkg::*;

  logic                         valid_q, valid_d;
  logic signed [DATA_WIDTH-1:0] value_q, value_d;
  logic [POS_WIDTH-1:0]         pos_q, pos_d;

  logic                         src_valid;
  logic signed [DATA_WIDTH-1:0] src_value;
  logic [POS_WIDTH-1:0]         src_pos;
  logic                         take_new;

  always_comb begin
    // source slot after an optional front pop
    src_valid = ctrl_i.shift ? nbr_valid_i : valid_q;
    src_value = ctrl_i.shift ? nbr_value_i : value_q;
    src_pos   = ctrl_i.shift ? nbr_pos_i   : pos_q;
    if (ctrl_i.clear) begin
      src_valid = 1'b0;
    end
    // strictly smaller candidates are popped from the back
    keep_o   = src_valid && (!ctrl_i.load || !(sample_i > src_value));
    take_new = ctrl_i.load && !keep_o && prev_keep_i;
    valid_d  = keep_o || take_new;
    value_d  = keep_o ? src_value : sample_i;
    pos_d    = keep_o ? src_pos   : sample_pos_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

  assign valid_o      = valid_q;
  assign value_o      = value_q;
  assign pos_o        = pos_q;
  assign value_next_o = value_d;

endmodule
